/* src/sbeh_pkg.sv */
// ----------------------------------------------------------------------------
// sbeh_pkg
// Shared types and constants of the swept box earliest hit core.
// ----------------------------------------------------------------------------
package sbeh_pkg;

   localparam int DEF_COORD_BITS = 24;
   localparam int HALF_BITS      = 16;
   localparam int TIME_BITS      = 18;
   localparam int NORM_BITS      = 2;
   localparam int Q16_SHIFT      = 16;
   localparam int ONE_Q16        = 65536;
   localparam int TIME_MIN       = -131072;
   localparam int TIME_MAX       = 65535;

   typedef enum logic [1:0] {
      OP_XLO,
      OP_XHI,
      OP_YLO,
      OP_YHI
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_XCHK,
      S_DIV_GO,
      S_DIV_WAIT,
      S_YCHK,
      S_EVAL,
      S_HCHK,
      S_MUL,
      S_HPT,
      S_NRM,
      S_FIN,
      S_RPT
   } state_type;

   typedef struct packed {
      logic   load;
      logic   div_start;
      op_type div_op;
      logic   eval;
      logic   mul;
      logic   hpt;
      logic   upd;
      logic   report;
   } cmd_type;

   typedef struct packed {
      logic dx_zero;
      logic dy_zero;
      logic x_out;
      logic y_out;
      logic div_done;
      logic div_busy;
      logic hit_ok;
      logic last;
      logic rsp_free;
   } status_type;

endpackage

/* src/sbeh_div.sv */
// ----------------------------------------------------------------------------
// sbeh_div
// Restoring divider, one quotient bit per cycle, signed result from
// magnitudes and a sign flag. Truncates toward zero.
// ----------------------------------------------------------------------------
module sbeh_div #(
   parameter int NUM_BITS = 43,
   parameter int DEN_BITS = 25
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_BITS-1:0]        num_mag,
   input  logic [DEN_BITS-1:0]        den_mag,
   input  logic                       neg,
   output logic                       busy,
   output logic                       done,
   output logic signed [NUM_BITS:0]   quo
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [DEN_BITS:0]   rem_sh;
   logic [DEN_BITS:0]   rem_sub;
   logic                q_bit;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[NUM_BITS-1]};
      q_bit   = (rem_sh >= {1'b0, den_ff});
      rem_sub = rem_sh - {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      if (start) begin
         q_in    = num_mag;
         rem_in  = '0;
         den_in  = den_mag;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
         neg_in  = neg;
      end else if (busy_ff) begin
         q_in   = {q_ff[NUM_BITS-2:0], q_bit};
         rem_in = q_bit ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

endmodule

/* src/sbeh_datapath.sv */
// ----------------------------------------------------------------------------
// sbeh_datapath
// Operand registers, slab times, hit point, normal, kept best hit and the
// result register.
// ----------------------------------------------------------------------------
module sbeh_datapath #(
   parameter int COORD_BITS = sbeh_pkg::DEF_COORD_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  sbeh_pkg::cmd_type                       cmd,
   output sbeh_pkg::status_type                    st,
   input  logic signed [COORD_BITS-1:0]            req_mover_x,
   input  logic signed [COORD_BITS-1:0]            req_mover_y,
   input  logic [sbeh_pkg::HALF_BITS-1:0]          req_mover_half_w,
   input  logic [sbeh_pkg::HALF_BITS-1:0]          req_mover_half_h,
   input  logic signed [COORD_BITS-1:0]            req_move_dx,
   input  logic signed [COORD_BITS-1:0]            req_move_dy,
   input  logic signed [COORD_BITS-1:0]            req_box_x,
   input  logic signed [COORD_BITS-1:0]            req_box_y,
   input  logic [sbeh_pkg::HALF_BITS-1:0]          req_box_half_w,
   input  logic [sbeh_pkg::HALF_BITS-1:0]          req_box_half_h,
   input  logic                                    req_last_box,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_hit_found,
   output logic signed [sbeh_pkg::TIME_BITS-1:0]   rsp_hit_time,
   output logic signed [COORD_BITS-1:0]            rsp_hit_x,
   output logic signed [COORD_BITS-1:0]            rsp_hit_y,
   output logic signed [sbeh_pkg::NORM_BITS-1:0]   rsp_normal_x,
   output logic signed [sbeh_pkg::NORM_BITS-1:0]   rsp_normal_y
);

   localparam int C   = COORD_BITS;
   localparam int TB  = sbeh_pkg::TIME_BITS;
   localparam int NB  = sbeh_pkg::NORM_BITS;
   localparam int XB  = sbeh_pkg::HALF_BITS + 1;   // grown half extent
   localparam int EW  = C + 2;                      // slab edge
   localparam int DFW = C + 3;                      // edge minus origin
   localparam int NW  = DFW + sbeh_pkg::Q16_SHIFT;  // numerator magnitude
   localparam int QW  = NW + 1;                     // signed quotient
   localparam int PW  = C + 1 + TB;                 // displacement times time
   localparam int SW  = C + 4;                      // hit point sum

   localparam logic signed [QW-1:0] T_ONE  = QW'(sbeh_pkg::ONE_Q16);
   localparam logic signed [QW-1:0] T_MIN  = QW'(sbeh_pkg::TIME_MIN);
   localparam logic signed [QW-1:0] T_ZERO = '0;
   localparam logic signed [C:0]    O_ZERO = '0;
   localparam logic signed [TB-1:0] TS_MIN = TB'(sbeh_pkg::TIME_MIN);
   localparam logic signed [TB-1:0] TS_MAX = TB'(sbeh_pkg::TIME_MAX);
   localparam logic signed [SW-1:0] C_HI   = SW'((64'sd1 <<< (C - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] C_LO   = -C_HI - SW'(1);
   localparam logic signed [NB-1:0] N_POS  = NB'(1);
   localparam logic signed [NB-1:0] N_NEG  = -NB'(1);

   // item operands
   logic signed [C-1:0]  px_ff, py_ff, bx_ff, by_ff;
   logic signed [C:0]    dx2_ff, dy2_ff;
   logic [XB-1:0]        exw_ff, exh_ff;
   logic                 last_ff;
   // slab edges
   logic signed [EW-1:0] lox_ff, hix_ff, loy_ff, hiy_ff;
   // slab times in operation order
   logic signed [QW-1:0] t_ff [4];
   // hit evaluation
   logic                 hit_ff, hit_in;
   logic signed [TB-1:0] ts_ff, ts_in;
   logic signed [PW-1:0] prx_ff, pry_ff;
   logic signed [C-1:0]  hx_ff, hy_ff;
   // kept best hit
   logic                 bv_ff, bv_in;
   logic signed [TB-1:0] bt_ff, bt_in;
   logic signed [C-1:0]  bpx_ff, bpx_in, bpy_ff, bpy_in;
   logic signed [NB-1:0] bnx_ff, bnx_in, bny_ff, bny_in;
   // result register
   logic                 rv_ff, rv_in;
   logic                 rf_ff;
   logic signed [TB-1:0] rt_ff;
   logic signed [C-1:0]  rx_ff, ry_ff;
   logic signed [NB-1:0] rnx_ff, rny_ff;

   // ---------------- divider operands
   logic signed [EW-1:0]  edge_sel;
   logic signed [C-1:0]   org_sel;
   logic signed [C:0]     d_sel;
   logic signed [DFW-1:0] diff;
   logic [DFW-1:0]        diff_mag;
   logic [C:0]            d_mag;
   logic                  div_busy, div_done;
   logic signed [QW-1:0]  quo;

   always_comb begin
      case (cmd.div_op)
         sbeh_pkg::OP_XLO: begin
            edge_sel = lox_ff; org_sel = px_ff; d_sel = dx2_ff;
         end
         sbeh_pkg::OP_XHI: begin
            edge_sel = hix_ff; org_sel = px_ff; d_sel = dx2_ff;
         end
         sbeh_pkg::OP_YLO: begin
            edge_sel = loy_ff; org_sel = py_ff; d_sel = dy2_ff;
         end
         default: begin
            edge_sel = hiy_ff; org_sel = py_ff; d_sel = dy2_ff;
         end
      endcase
      diff     = DFW'(edge_sel) - DFW'(org_sel);
      diff_mag = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
      d_mag    = d_sel[C] ? (C+1)'(-d_sel) : (C+1)'(d_sel);
   end

   sbeh_div #(
      .NUM_BITS(NW),
      .DEN_BITS(C + 1)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .num_mag({diff_mag, {sbeh_pkg::Q16_SHIFT{1'b0}}}),
      .den_mag(d_mag),
      .neg    (diff[DFW-1] ^ d_sel[C]),
      .busy   (div_busy),
      .done   (div_done),
      .quo    (quo)
   );

   // ---------------- slab combine and hit test
   logic                 x_used, y_used;
   logic signed [QW-1:0] enx, exx, eny, exy, ent, ext;

   always_comb begin
      x_used = (dx2_ff != '0);
      y_used = (dy2_ff != '0);
      enx = (t_ff[0] < t_ff[1]) ? t_ff[0] : t_ff[1];
      exx = (t_ff[0] < t_ff[1]) ? t_ff[1] : t_ff[0];
      eny = (t_ff[2] < t_ff[3]) ? t_ff[2] : t_ff[3];
      exy = (t_ff[2] < t_ff[3]) ? t_ff[3] : t_ff[2];
      if (x_used && y_used) begin
         ent = (eny > enx) ? eny : enx;
         ext = (exy < exx) ? exy : exx;
      end else if (x_used) begin
         ent = enx;
         ext = exx;
      end else begin
         ent = eny;
         ext = exy;
      end
      hit_in = (x_used || y_used) && (ext > ent) && (ext > T_ZERO) && (ent < T_ONE);
      ts_in  = (ent < T_MIN) ? TS_MIN : ent[TB-1:0];
   end

   // ---------------- hit point
   logic signed [SW-1:0] sx, sy;
   logic signed [C-1:0]  hx_in, hy_in;

   always_comb begin
      sx    = SW'(px_ff) + SW'(prx_ff >>> sbeh_pkg::Q16_SHIFT);
      sy    = SW'(py_ff) + SW'(pry_ff >>> sbeh_pkg::Q16_SHIFT);
      hx_in = (sx > C_HI) ? C_HI[C-1:0] : ((sx < C_LO) ? C_LO[C-1:0] : sx[C-1:0]);
      hy_in = (sy > C_HI) ? C_HI[C-1:0] : ((sy < C_LO) ? C_LO[C-1:0] : sy[C-1:0]);
   end

   // ---------------- normal and keep decision
   logic signed [C:0]    ox, oy;
   logic [C:0]           aox, aoy, adx, ady;
   logic signed [C+2:0]  penx, peny;
   logic signed [NB-1:0] nx, ny;
   logic                 take;

   always_comb begin
      ox   = (C+1)'(hx_ff) - (C+1)'(bx_ff);
      oy   = (C+1)'(hy_ff) - (C+1)'(by_ff);
      aox  = ox[C] ? (C+1)'(-ox) : (C+1)'(ox);
      aoy  = oy[C] ? (C+1)'(-oy) : (C+1)'(oy);
      adx  = dx2_ff[C] ? (C+1)'(-dx2_ff) : (C+1)'(dx2_ff);
      ady  = dy2_ff[C] ? (C+1)'(-dy2_ff) : (C+1)'(dy2_ff);
      penx = $signed((C+3)'(exw_ff)) - $signed((C+3)'(aox));
      peny = $signed((C+3)'(exh_ff)) - $signed((C+3)'(aoy));
      nx   = '0;
      ny   = '0;
      if (penx < peny) begin
         nx = (ox > O_ZERO) ? N_POS : ((ox < O_ZERO) ? N_NEG : '0);
      end else begin
         ny = (oy > O_ZERO) ? N_POS : ((oy < O_ZERO) ? N_NEG : '0);
      end
      take = !bv_ff || (ts_ff < bt_ff) ||
             ((ts_ff == bt_ff) && (((adx > ady) && (nx != '0)) ||
                                   ((ady > adx) && (ny != '0))));
   end

   // ---------------- best hit and result register
   always_comb begin
      bv_in  = bv_ff;
      bt_in  = bt_ff;
      bpx_in = bpx_ff;
      bpy_in = bpy_ff;
      bnx_in = bnx_ff;
      bny_in = bny_ff;
      rv_in  = rv_ff && !rsp_ready;
      if (cmd.upd && take) begin
         bv_in  = 1'b1;
         bt_in  = ts_ff;
         bpx_in = hx_ff;
         bpy_in = hy_ff;
         bnx_in = nx;
         bny_in = ny;
      end
      if (cmd.report) begin
         rv_in  = 1'b1;
         bv_in  = 1'b0;
         bt_in  = TS_MAX;
         bpx_in = '0;
         bpy_in = '0;
         bnx_in = '0;
         bny_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff  <= 1'b0;
         bt_ff  <= TS_MAX;
         bpx_ff <= '0;
         bpy_ff <= '0;
         bnx_ff <= '0;
         bny_ff <= '0;
         rv_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         bv_ff  <= bv_in;
         bt_ff  <= bt_in;
         bpx_ff <= bpx_in;
         bpy_ff <= bpy_in;
         bnx_ff <= bnx_in;
         bny_ff <= bny_in;
         rv_ff  <= rv_in;
         if (cmd.eval) begin
            hit_ff <= hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff   <= req_mover_x;
         py_ff   <= req_mover_y;
         dx2_ff  <= (C+1)'(req_move_dx) <<< 1;
         dy2_ff  <= (C+1)'(req_move_dy) <<< 1;
         bx_ff   <= req_box_x;
         by_ff   <= req_box_y;
         exw_ff  <= XB'(req_box_half_w) + XB'(req_mover_half_w);
         exh_ff  <= XB'(req_box_half_h) + XB'(req_mover_half_h);
         last_ff <= req_last_box;
      end
      lox_ff <= EW'(bx_ff) - $signed(EW'(exw_ff));
      hix_ff <= EW'(bx_ff) + $signed(EW'(exw_ff));
      loy_ff <= EW'(by_ff) - $signed(EW'(exh_ff));
      hiy_ff <= EW'(by_ff) + $signed(EW'(exh_ff));
      if (div_done) begin
         t_ff[cmd.div_op] <= quo;
      end
      if (cmd.eval) begin
         ts_ff <= ts_in;
      end
      if (cmd.mul) begin
         prx_ff <= PW'(dx2_ff * ts_ff);
         pry_ff <= PW'(dy2_ff * ts_ff);
      end
      if (cmd.hpt) begin
         hx_ff <= hx_in;
         hy_ff <= hy_in;
      end
      if (cmd.report) begin
         rf_ff  <= bv_ff;
         rt_ff  <= bv_ff ? bt_ff : '0;
         rx_ff  <= bpx_ff;
         ry_ff  <= bpy_ff;
         rnx_ff <= bnx_ff;
         rny_ff <= bny_ff;
      end
   end

   always_comb begin
      st.dx_zero  = !x_used;
      st.dy_zero  = !y_used;
      st.x_out    = (EW'(px_ff) <= lox_ff) || (EW'(px_ff) >= hix_ff);
      st.y_out    = (EW'(py_ff) <= loy_ff) || (EW'(py_ff) >= hiy_ff);
      st.div_done = div_done;
      st.div_busy = div_busy;
      st.hit_ok   = hit_ff;
      st.last     = last_ff;
      st.rsp_free = !rv_ff || rsp_ready;
   end

   assign rsp_valid     = rv_ff;
   assign rsp_hit_found = rf_ff;
   assign rsp_hit_time  = rt_ff;
   assign rsp_hit_x     = rx_ff;
   assign rsp_hit_y     = ry_ff;
   assign rsp_normal_x  = rnx_ff;
   assign rsp_normal_y  = rny_ff;

endmodule

/* src/sbeh_ctrl.sv */
// ----------------------------------------------------------------------------
// sbeh_ctrl
// Sequencer: load, slab divisions, hit evaluation, update and report.
// ----------------------------------------------------------------------------
module sbeh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sbeh_pkg::status_type st,
   output sbeh_pkg::cmd_type    cmd
);

   sbeh_pkg::state_type state_ff, state_in;
   sbeh_pkg::op_type    op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         sbeh_pkg::S_IDLE: if (req_valid) state_in = sbeh_pkg::S_PREP;
         sbeh_pkg::S_PREP: state_in = sbeh_pkg::S_XCHK;
         sbeh_pkg::S_XCHK: begin
            if (st.dx_zero) begin
               state_in = st.x_out ? sbeh_pkg::S_FIN : sbeh_pkg::S_YCHK;
            end else begin
               op_in    = sbeh_pkg::OP_XLO;
               state_in = sbeh_pkg::S_DIV_GO;
            end
         end
         sbeh_pkg::S_DIV_GO: state_in = sbeh_pkg::S_DIV_WAIT;
         sbeh_pkg::S_DIV_WAIT: begin
            if (st.div_done) begin
               unique case (op_ff)
                  sbeh_pkg::OP_XLO: begin
                     op_in    = sbeh_pkg::OP_XHI;
                     state_in = sbeh_pkg::S_DIV_GO;
                  end
                  sbeh_pkg::OP_XHI: state_in = sbeh_pkg::S_YCHK;
                  sbeh_pkg::OP_YLO: begin
                     op_in    = sbeh_pkg::OP_YHI;
                     state_in = sbeh_pkg::S_DIV_GO;
                  end
                  default: state_in = sbeh_pkg::S_EVAL;
               endcase
            end
         end
         sbeh_pkg::S_YCHK: begin
            if (st.dy_zero) begin
               state_in = st.y_out ? sbeh_pkg::S_FIN : sbeh_pkg::S_EVAL;
            end else begin
               op_in    = sbeh_pkg::OP_YLO;
               state_in = sbeh_pkg::S_DIV_GO;
            end
         end
         sbeh_pkg::S_EVAL: state_in = sbeh_pkg::S_HCHK;
         sbeh_pkg::S_HCHK: state_in = st.hit_ok ? sbeh_pkg::S_MUL : sbeh_pkg::S_FIN;
         sbeh_pkg::S_MUL:  state_in = sbeh_pkg::S_HPT;
         sbeh_pkg::S_HPT:  state_in = sbeh_pkg::S_NRM;
         sbeh_pkg::S_NRM:  state_in = sbeh_pkg::S_FIN;
         sbeh_pkg::S_FIN:  state_in = st.last ? sbeh_pkg::S_RPT : sbeh_pkg::S_IDLE;
         sbeh_pkg::S_RPT:  if (st.rsp_free) state_in = sbeh_pkg::S_IDLE;
         default:          state_in = sbeh_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.div_op    = op_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         sbeh_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         sbeh_pkg::S_DIV_GO: cmd.div_start = 1'b1;
         sbeh_pkg::S_EVAL:   cmd.eval      = 1'b1;
         sbeh_pkg::S_MUL:    cmd.mul       = 1'b1;
         sbeh_pkg::S_HPT:    cmd.hpt       = 1'b1;
         sbeh_pkg::S_NRM:    cmd.upd       = 1'b1;
         sbeh_pkg::S_RPT:    cmd.report    = st.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbeh_pkg::S_IDLE;
         op_ff    <= sbeh_pkg::OP_XLO;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

/* src/swept_box_earliest_hit_core.sv */
// ----------------------------------------------------------------------------
// swept_box_earliest_hit_core
// Earliest hit of a swept box against a list of obstacle boxes.
// ----------------------------------------------------------------------------
// Usage: send one transaction per obstacle on the req_ channel (valid/ready),
// each carrying the mover box, its displacement and the obstacle. The sweep
// looks two displacements ahead. Mark the final obstacle with req_last_box;
// one rsp_ transaction then carries the earliest hit (or hit_found 0 with all
// fields zero) and the kept hit clears for the next sweep.
// Timing: a transaction runs from accept to completion before the next accept
// (the last of a sweep also passes through the report state); each
// axis with non-zero displacement costs two divisions on the single shared
// divider, one quotient bit per cycle (COORD_BITS+19 bits), and the divider
// sets the rate. An axis with zero displacement skips its divisions.
// Reset: synchronous, active high; clears the sequencer, the kept hit and
// the valid flag of the result register.
// Stall: the result waits in an output register while the next obstacle is
// taken; only a second result stalls the sequencer until rsp_ready.
// ----------------------------------------------------------------------------
module swept_box_earliest_hit_core #(
   parameter int COORD_BITS = sbeh_pkg::DEF_COORD_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [COORD_BITS-1:0]            req_mover_x,
   input  logic signed [COORD_BITS-1:0]            req_mover_y,
   input  logic [sbeh_pkg::HALF_BITS-1:0]          req_mover_half_w,
   input  logic [sbeh_pkg::HALF_BITS-1:0]          req_mover_half_h,
   input  logic signed [COORD_BITS-1:0]            req_move_dx,
   input  logic signed [COORD_BITS-1:0]            req_move_dy,
   input  logic signed [COORD_BITS-1:0]            req_box_x,
   input  logic signed [COORD_BITS-1:0]            req_box_y,
   input  logic [sbeh_pkg::HALF_BITS-1:0]          req_box_half_w,
   input  logic [sbeh_pkg::HALF_BITS-1:0]          req_box_half_h,
   input  logic                                    req_last_box,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_hit_found,
   output logic signed [sbeh_pkg::TIME_BITS-1:0]   rsp_hit_time,
   output logic signed [COORD_BITS-1:0]            rsp_hit_x,
   output logic signed [COORD_BITS-1:0]            rsp_hit_y,
   output logic signed [sbeh_pkg::NORM_BITS-1:0]   rsp_normal_x,
   output logic signed [sbeh_pkg::NORM_BITS-1:0]   rsp_normal_y
);

   sbeh_pkg::cmd_type    cmd;
   sbeh_pkg::status_type st;

   // sequencer: one transaction at a time
   sbeh_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .st       (st),
      .cmd      (cmd)
   );

   // arithmetic, kept hit and result register
   sbeh_datapath #(
      .COORD_BITS(COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_mover_x     (req_mover_x),
      .req_mover_y     (req_mover_y),
      .req_mover_half_w(req_mover_half_w),
      .req_mover_half_h(req_mover_half_h),
      .req_move_dx     (req_move_dx),
      .req_move_dy     (req_move_dy),
      .req_box_x       (req_box_x),
      .req_box_y       (req_box_y),
      .req_box_half_w  (req_box_half_w),
      .req_box_half_h  (req_box_half_h),
      .req_last_box    (req_last_box),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit_found   (rsp_hit_found),
      .rsp_hit_time    (rsp_hit_time),
      .rsp_hit_x       (rsp_hit_x),
      .rsp_hit_y       (rsp_hit_y),
      .rsp_normal_x    (rsp_normal_x),
      .rsp_normal_y    (rsp_normal_y)
   );

   // never accept while a division runs
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && st.div_busy))
      else $error("transaction accepted while divider busy");

   // one transaction in flight: ready drops after accept
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held after accept");

   // a miss report carries zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit_found) |-> (rsp_hit_time == '0 && rsp_hit_x == '0 &&
         rsp_hit_y == '0 && rsp_normal_x == '0 && rsp_normal_y == '0))
      else $error("miss report with non-zero fields");

   // the normal lies on one axis at most
   a_normal_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_normal_x != '0 && rsp_normal_y != '0))
      else $error("normal on both axes");

endmodule

/* tb/sv/swept_box_earliest_hit_core_tb.sv */
// ----------------------------------------------------------------------------
// swept_box_earliest_hit_core_tb
// Self-checking bench for the swept box earliest hit core.
// ----------------------------------------------------------------------------
// Sweeps of obstacle transactions go in on the req_ channel. A model of the
// slab test and of the earliest-hit selection, kept inside this bench,
// predicts the report of each sweep. Every rsp_ transaction is checked field
// by field against the oldest prediction. Directed cases come first, then
// random sweeps under four idling regimes.
// ----------------------------------------------------------------------------
module swept_box_earliest_hit_core_tb;

   localparam int CB = sbeh_pkg::DEF_COORD_BITS;
   localparam int HB = sbeh_pkg::HALF_BITS;
   localparam int TB = sbeh_pkg::TIME_BITS;
   localparam int NB = sbeh_pkg::NORM_BITS;

   typedef struct {
      logic signed [CB-1:0]  mover_x, mover_y;
      logic [HB-1:0]         mover_half_w, mover_half_h;
      logic signed [CB-1:0]  move_dx, move_dy;
      logic signed [CB-1:0]  box_x, box_y;
      logic [HB-1:0]         box_half_w, box_half_h;
      logic                  last_box;
   } obstacle_type;

   typedef struct {
      logic                  found;
      logic signed [TB-1:0]  hit_time;
      logic signed [CB-1:0]  hit_x, hit_y;
      logic signed [NB-1:0]  nx, ny;
   } hit_report_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic signed [CB-1:0] req_mover_x, req_mover_y, req_move_dx, req_move_dy;
   logic signed [CB-1:0] req_box_x, req_box_y;
   logic [HB-1:0] req_mover_half_w, req_mover_half_h;
   logic [HB-1:0] req_box_half_w, req_box_half_h;
   logic req_last_box;
   logic rsp_valid, rsp_ready, rsp_hit_found;
   logic signed [TB-1:0] rsp_hit_time;
   logic signed [CB-1:0] rsp_hit_x, rsp_hit_y;
   logic signed [NB-1:0] rsp_normal_x, rsp_normal_y;

   // expected reports, oldest first
   hit_report_type expected_reports[$];
   int             mismatches;
   int             send_idle_pct;
   int             recv_stall_pct;

   // kept-hit state of the predictor
   bit     kept_valid;
   longint kept_time, kept_px, kept_py, kept_nx, kept_ny;

   swept_box_earliest_hit_core u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Time limit: far above the slowest legal run, idling and stalls
   // included.
   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void clear_kept();
      kept_valid = 1'b0;
      kept_time  = sbeh_pkg::TIME_MAX;
      kept_px    = 0;
      kept_py    = 0;
      kept_nx    = 0;
      kept_ny    = 0;
   endfunction

   function automatic longint floor_div_q16(longint v);
      if (v >= 0) return v / sbeh_pkg::ONE_Q16;
      return -((-v + (sbeh_pkg::ONE_Q16 - 1)) / sbeh_pkg::ONE_Q16);
   endfunction

   function automatic longint clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (CB - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   // Narrow the entry/exit window by one axis; return 1 when the axis misses.
   function automatic bit clip_axis(input longint p, d, lo, hi,
                                    inout bit seen, inout longint t_in, t_out);
      longint t1, t2, en, ex;
      if (d == 0) return (p <= lo || p >= hi);
      t1 = ((lo - p) * sbeh_pkg::ONE_Q16) / d;
      t2 = ((hi - p) * sbeh_pkg::ONE_Q16) / d;
      en = t1 < t2 ? t1 : t2;
      ex = t1 < t2 ? t2 : t1;
      if (!seen) begin
         t_in  = en;
         t_out = ex;
         seen  = 1'b1;
      end else begin
         if (en > t_in) t_in = en;
         if (ex < t_out) t_out = ex;
      end
      return 1'b0;
   endfunction

   // Fold one obstacle into the kept hit; queue a report on the last one.
   function automatic void predict_obstacle(obstacle_type o);
      longint px, py, dx, dy, bx, by, ew, eh, t_in, t_out, ts, hx, hy, ox, oy;
      longint nx, ny;
      bit seen, miss, take;
      hit_report_type rep;
      px = o.mover_x;  py = o.mover_y;
      dx = 2 * longint'(o.move_dx);
      dy = 2 * longint'(o.move_dy);
      bx = o.box_x;    by = o.box_y;
      ew = longint'(o.box_half_w) + longint'(o.mover_half_w);
      eh = longint'(o.box_half_h) + longint'(o.mover_half_h);
      seen = 1'b0; t_in = 0; t_out = 0;
      miss = clip_axis(px, dx, bx - ew, bx + ew, seen, t_in, t_out);
      if (!miss) miss = clip_axis(py, dy, by - eh, by + eh, seen, t_in, t_out);
      if (!miss && seen && t_out > t_in && t_out > 0 && t_in < sbeh_pkg::ONE_Q16) begin
         ts = t_in < sbeh_pkg::TIME_MIN ? sbeh_pkg::TIME_MIN : t_in;
         hx = clamp_coord(px + floor_div_q16(dx * ts));
         hy = clamp_coord(py + floor_div_q16(dy * ts));
         ox = hx - bx;
         oy = hy - by;
         nx = 0; ny = 0;
         if (ew - mag(ox) < eh - mag(oy)) nx = sign_of(ox);
         else ny = sign_of(oy);
         if (!kept_valid || ts < kept_time) take = 1'b1;
         else if (ts == kept_time)
            take = (mag(dx) > mag(dy) && nx != 0) || (mag(dy) > mag(dx) && ny != 0);
         else take = 1'b0;
         if (take) begin
            kept_valid = 1'b1;
            kept_time  = ts;
            kept_px    = hx;
            kept_py    = hy;
            kept_nx    = nx;
            kept_ny    = ny;
         end
      end
      if (o.last_box) begin
         rep.found    = kept_valid;
         rep.hit_time = kept_valid ? kept_time : 0;
         rep.hit_x    = kept_px;
         rep.hit_y    = kept_py;
         rep.nx       = kept_nx;
         rep.ny       = kept_ny;
         expected_reports.push_back(rep);
         clear_kept();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driving and checking
   // ---------------------------------------------------------------------
   // Hold each transaction until accepted; idle before it at the set rate.
   task automatic send_obstacle(obstacle_type o);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mover_x      <= o.mover_x;
      req_mover_y      <= o.mover_y;
      req_mover_half_w <= o.mover_half_w;
      req_mover_half_h <= o.mover_half_h;
      req_move_dx      <= o.move_dx;
      req_move_dy      <= o.move_dy;
      req_box_x        <= o.box_x;
      req_box_y        <= o.box_y;
      req_box_half_w   <= o.box_half_w;
      req_box_half_h   <= o.box_half_h;
      req_last_box     <= o.last_box;
      do @(posedge clock); while (!req_ready);
      predict_obstacle(o);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      hit_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, actual found=%0d time=%0d",
                     $time, rsp_hit_found, rsp_hit_time);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            check_field("hit_found", want.found, rsp_hit_found);
            check_field("hit_time", want.hit_time, rsp_hit_time);
            check_field("hit_x", want.hit_x, rsp_hit_x);
            check_field("hit_y", want.hit_y, rsp_hit_y);
            check_field("normal_x", want.nx, rsp_normal_x);
            check_field("normal_y", want.ny, rsp_normal_y);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   function automatic obstacle_type mk(int mx, int my, int mw, int mh, int dx, int dy,
                                       int bx, int by, int bw, int bh, bit last);
      obstacle_type o;
      o.mover_x = mx;  o.mover_y = my;  o.mover_half_w = mw; o.mover_half_h = mh;
      o.move_dx = dx;  o.move_dy = dy;  o.box_x = bx;        o.box_y = by;
      o.box_half_w = bw; o.box_half_h = bh; o.last_box = last;
      return o;
   endfunction

   // Mostly boxes placed along the swept path; now and then raw bit patterns.
   function automatic obstacle_type random_obstacle(bit last);
      obstacle_type o;
      int k;
      if ($urandom_range(9) == 0) begin
         o = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, last);
         return o;
      end
      o.mover_x = int'($urandom_range(80000)) - 40000;
      o.mover_y = int'($urandom_range(80000)) - 40000;
      o.mover_half_w = $urandom_range(2000);
      o.mover_half_h = $urandom_range(2000);
      o.move_dx = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(16000)) - 8000;
      o.move_dy = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(16000)) - 8000;
      k = $urandom_range(160);
      o.box_x = o.mover_x + (int'(o.move_dx) * k) / 64 + int'($urandom_range(3000)) - 1500;
      o.box_y = o.mover_y + (int'(o.move_dy) * k) / 64 + int'($urandom_range(3000)) - 1500;
      o.box_half_w = $urandom_range(3000);
      o.box_half_h = $urandom_range(3000);
      o.last_box = last;
      return o;
   endfunction

   // Sweeps of one to six obstacles until about n transactions have gone.
   task automatic run_sweeps(int n);
      int sent;
      int len;
      sent = 0;
      while (sent < n) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) send_obstacle(random_obstacle(i == len - 1));
         sent += len;
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0; recv_stall_pct = 0;
      // plain hit on the x axis
      send_obstacle(mk(0, 0, 256, 256, 1024, 0, 1536, 0, 256, 256, 1));
      // clean miss, report with nothing kept
      send_obstacle(mk(0, 0, 256, 256, 1024, 0, 1536, 9000, 256, 256, 1));
      // no displacement at all
      send_obstacle(mk(0, 0, 256, 256, 0, 0, 0, 0, 256, 256, 1));
      // still x inside the slab, moving y
      send_obstacle(mk(100, 0, 256, 256, 0, 800, 0, 1500, 256, 256, 1));
      // still x exactly on the slab edge
      send_obstacle(mk(512, 0, 256, 256, 0, 800, 0, 1500, 256, 256, 1));
      // equal times, x faster
      send_obstacle(mk(0, 0, 128, 128, 2000, 500, 3000, 700, 256, 256, 0));
      send_obstacle(mk(0, 0, 128, 128, 2000, 500, 3000, 700, 256, 256, 1));
      // y faster; the first box is hit on its y face, the second box is missed
      send_obstacle(mk(0, 0, 128, 128, 400, 2000, 600, 3000, 256, 256, 0));
      send_obstacle(mk(0, 0, 128, 128, 400, 2000, 1100, 2400, 300, 300, 1));
      // start deep inside: entry saturates at -2.0
      send_obstacle(mk(0, 0, 256, 256, 1, 1, 0, 0, 4000, 4000, 1));
      // later obstacle nearer than the first
      send_obstacle(mk(0, 0, 64, 64, -3000, -3000, -5000, -5000, 200, 200, 0));
      send_obstacle(mk(0, 0, 64, 64, -3000, -3000, -1500, -1500, 200, 200, 0));
      send_obstacle(mk(0, 0, 64, 64, -3000, -3000, 9000, 9000, 200, 200, 1));
      // field extremes
      send_obstacle(mk(8388607, 8388607, 65535, 65535, -8388608, -8388608,
                       -8388608, -8388608, 65535, 65535, 1));
      send_obstacle(mk(-8388608, -8388608, 0, 0, 8388607, 8388607,
                       8388607, 8388607, 0, 0, 1));
      send_obstacle(mk(8388600, 0, 65535, 65535, 8388607, 1, 8388607, 0, 65535, 65535, 1));
      send_obstacle(mk(-8388608, 8388607, 65535, 0, -1, 8388607,
                       -8388608, 8388607, 0, 65535, 1));
      send_obstacle(mk(0, 0, 0, 0, 1, -1, 1, -1, 1, 1, 1));
   endtask

   task automatic test_no_idling();
      send_idle_pct = 0;  recv_stall_pct = 0;
      run_sweeps(330);
   endtask

   task automatic test_sender_idle();
      send_idle_pct = 84; recv_stall_pct = 0;
      run_sweeps(330);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct = 0;  recv_stall_pct = 84;
      run_sweeps(330);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 19; recv_stall_pct = 19;
      run_sweeps(330);
   endtask

   initial begin
      mismatches = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      clear_kept();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_mover_x      <= '0;
      req_mover_y      <= '0;
      req_mover_half_w <= '0;
      req_mover_half_h <= '0;
      req_move_dx      <= '0;
      req_move_dy      <= '0;
      req_box_x        <= '0;
      req_box_y        <= '0;
      req_box_half_w   <= '0;
      req_box_half_h   <= '0;
      req_last_box     <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();

      // drop valid, drain the reports, then allow for one more pass
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      if (mismatches == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

/* files.f */
src/sbeh_pkg.sv
src/sbeh_div.sv
src/sbeh_datapath.sv
src/sbeh_ctrl.sv
src/swept_box_earliest_hit_core.sv
tb/sv/swept_box_earliest_hit_core_tb.sv
